// File: hdl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg : shared types and constants for the sphere/frustum culling block
// Fixed-point widths, configuration layout and small helper functions.
// ----------------------------------------------------------------------------
package scf_pkg;

   localparam int COORD_W = 21;            // Q12.8 signed coordinate
   localparam int RAD_W   = 20;            // Q12.8 unsigned radius
   localparam int COEF_W  = 16;            // Q1.14 signed coefficient
   localparam int FRAC_W  = 14;            // coefficient fraction bits
   localparam int PROD_W  = COORD_W + COEF_W;   // 37
   localparam int ACC_W   = PROD_W + 3;         // 40, three products plus offset
   localparam int VIEW_W  = ACC_W - FRAC_W;     // 26, unclamped view coordinate
   localparam int PLN_W   = VIEW_W + COEF_W;    // 42, one plane product
   localparam int DIST_W  = PLN_W + 1;          // 43, plane distance
   localparam int CMP_W   = DIST_W + 1;         // 44, compare width
   localparam int DEP_W   = VIEW_W + 2;         // 28, depth compare width
   localparam int ROW_W   = 3 * COEF_W;         // 48
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [RAD_W-1:0]   radius_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [VIEW_W-1:0]  view_type;
   typedef logic signed [PLN_W-1:0]   pln_type;
   typedef logic signed [DIST_W-1:0]  dist_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_X_ROW       = 3'd0,
      CSR_VIEW_Y_ROW       = 3'd1,
      CSR_VIEW_Z_ROW       = 3'd2,
      CSR_VIEW_TRANSLATION = 3'd3,
      CSR_SIDE_PLANES      = 3'd4,
      CSR_VERTICAL_PLANES  = 3'd5,
      CSR_CLIP_DEPTHS      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]     x_row;
      logic [ROW_W-1:0]     y_row;
      logic [ROW_W-1:0]     z_row;
      logic [3*COORD_W-1:0] translation;
      logic [4*COEF_W-1:0]  side_planes;
      logic [4*COEF_W-1:0]  vertical_planes;
      logic [2*COORD_W-1:0] clip_depths;
   } cfg_type;

   // stage advance enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

   function automatic coef_type coef_at(input logic [4*COEF_W-1:0] reg_val,
                                        input int unsigned k);
      coef_at = coef_type'(reg_val[COEF_W*k +: COEF_W]);
   endfunction

   // clamp a view coordinate to the 21-bit output range
   function automatic coord_type sat_view(input view_type v);
      logic hi_same;
      hi_same = (v[VIEW_W-1:COORD_W-1] == '0) || (v[VIEW_W-1:COORD_W-1] == '1);
      if (hi_same)
         sat_view = v[COORD_W-1:0];
      else if (v[VIEW_W-1])
         sat_view = {1'b1, {(COORD_W-1){1'b0}}};
      else
         sat_view = {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

endpackage

// File: hdl/scf_xform.sv
// ----------------------------------------------------------------------------
// scf_xform : world-to-view transform, stages 1 and 2
// Stage 1 forms the nine coefficient products, stage 2 sums each row with
// its offset, rounds and drops the coefficient fraction bits.
// ----------------------------------------------------------------------------
module scf_xform
   import scf_pkg::*;
(
   input  logic       clock,
   input  adv_type    adv,
   input  cfg_type    cfg,
   input  coord_type  center_x,
   input  coord_type  center_y,
   input  coord_type  center_z,
   input  radius_type radius,
   output view_type   view_x,
   output view_type   view_y,
   output view_type   view_z,
   output radius_type radius_out
);

   localparam acc_type ROUND = acc_type'(1) <<< (FRAC_W - 1);

   prod_type   prod_in [3][3];
   prod_type   prod_ff [3][3];
   radius_type rad1_ff;
   acc_type    acc_in  [3];
   view_type   view_ff [3];
   radius_type rad2_ff;

   logic [ROW_W-1:0] rows [3];

   assign rows[0] = cfg.x_row;
   assign rows[1] = cfg.y_row;
   assign rows[2] = cfg.z_row;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = center_x * coef_type'(rows[r][0*COEF_W +: COEF_W]);
         prod_in[r][1] = center_y * coef_type'(rows[r][1*COEF_W +: COEF_W]);
         prod_in[r][2] = center_z * coef_type'(rows[r][2*COEF_W +: COEF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff <= prod_in;
         rad1_ff <= radius;
      end
   end

   // floor of (sum + half) / 2^14 is an arithmetic drop of the low bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = acc_type'(prod_ff[r][0]) + acc_type'(prod_ff[r][1])
                   + acc_type'(prod_ff[r][2])
                   + (acc_type'(coord_type'(cfg.translation[COORD_W*r +: COORD_W]))
                      <<< FRAC_W)
                   + ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         for (int r = 0; r < 3; r++)
            view_ff[r] <= acc_in[r][ACC_W-1:FRAC_W];
         rad2_ff <= rad1_ff;
      end
   end

   assign view_x     = view_ff[0];
   assign view_y     = view_ff[1];
   assign view_z     = view_ff[2];
   assign radius_out = rad2_ff;

endmodule

// File: hdl/scf_test.sv
// ----------------------------------------------------------------------------
// scf_test : depth and side-plane tests, stages 3 and 4
// Stage 3 forms the plane products and the depth verdict, stage 4 adds the
// pairs, compares against the radius and holds the result item.
// ----------------------------------------------------------------------------
module scf_test
   import scf_pkg::*;
(
   input  logic       clock,
   input  adv_type    adv,
   input  cfg_type    cfg,
   input  view_type   view_x,
   input  view_type   view_y,
   input  view_type   view_z,
   input  radius_type radius,
   output logic       visible,
   output coord_type  sat_x,
   output coord_type  sat_y,
   output coord_type  sat_z
);

   pln_type    pln_in [8];
   pln_type    pln_ff [8];
   logic       depth_cull_in;
   logic       depth_cull_ff;
   coord_type  sat3_ff [3];
   radius_type rad3_ff;

   logic       plane_cull_in;
   logic       vis_ff;
   coord_type  sat4_ff [3];

   logic signed [DEP_W-1:0] vz_w, rad_w, front_w, back_w;
   logic signed [CMP_W-1:0] rw;
   dist_type                pln_dist [4];

   // order: left, right, top, bottom; even = lateral term, odd = depth term
   always_comb begin
      pln_in[0] = view_x * coef_at(cfg.side_planes, 0);
      pln_in[1] = view_z * coef_at(cfg.side_planes, 1);
      pln_in[2] = view_x * coef_at(cfg.side_planes, 2);
      pln_in[3] = view_z * coef_at(cfg.side_planes, 3);
      pln_in[4] = view_y * coef_at(cfg.vertical_planes, 0);
      pln_in[5] = view_z * coef_at(cfg.vertical_planes, 1);
      pln_in[6] = view_y * coef_at(cfg.vertical_planes, 2);
      pln_in[7] = view_z * coef_at(cfg.vertical_planes, 3);
   end

   always_comb begin
      vz_w    = DEP_W'(view_z);
      rad_w   = $signed({{(DEP_W-RAD_W){1'b0}}, radius});
      front_w = DEP_W'(coord_type'(cfg.clip_depths[0 +: COORD_W]));
      back_w  = DEP_W'(coord_type'(cfg.clip_depths[COORD_W +: COORD_W]));
      depth_cull_in = ((vz_w + rad_w) < front_w) || ((vz_w - rad_w) > back_w);
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         pln_ff        <= pln_in;
         depth_cull_ff <= depth_cull_in;
         sat3_ff[0]    <= sat_view(view_x);
         sat3_ff[1]    <= sat_view(view_y);
         sat3_ff[2]    <= sat_view(view_z);
         rad3_ff       <= radius;
      end
   end

   always_comb begin
      rw = $signed({{(CMP_W-RAD_W-FRAC_W){1'b0}}, rad3_ff, {FRAC_W{1'b0}}});
      plane_cull_in = 1'b0;
      for (int p = 0; p < 4; p++) begin
         pln_dist[p] = DIST_W'(pln_ff[2*p]) + DIST_W'(pln_ff[2*p+1]);
         if (CMP_W'(pln_dist[p]) > rw)
            plane_cull_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         vis_ff  <= !depth_cull_ff && !plane_cull_in;
         sat4_ff <= sat3_ff;
      end
   end

   assign visible = vis_ff;
   assign sat_x   = sat4_ff[0];
   assign sat_y   = sat4_ff[1];
   assign sat_z   = sat4_ff[2];

endmodule

// File: hdl/sphere_frustum_cull.sv
// ----------------------------------------------------------------------------
// sphere_frustum_cull : bounding-sphere view-frustum culling, top level
// Each accepted input item becomes one result item on rsp_.
// Throughput: one item per cycle while rsp_tready is high; the four stages each hold an item.
// Stages: products, transform sum, plane products + depth test, plane verdict.
// Reset (synchronous, active high) empties the pipe and loads the identity
// matrix, zero offsets, zero planes and zero clip depths.
// ----------------------------------------------------------------------------
module sphere_frustum_cull
   import scf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [87:0]          req_tdata,   // center_x, center_y, center_z, radius, pad
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,   // view_x, view_y, view_z, pad
   output logic [0:0]           rsp_tuser,   // visible
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   adv_type    adv;
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       v1_in, v2_in, v3_in, v4_in;

   coord_type  center_x, center_y, center_z;
   radius_type radius;
   view_type   view_x, view_y, view_z;
   radius_type radius_s2;
   logic       visible;
   coord_type  sat_x, sat_y, sat_z;

   // ---- configuration registers -------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW_X_ROW:       cfg_in.x_row           = csr_wdata[ROW_W-1:0];
            CSR_VIEW_Y_ROW:       cfg_in.y_row           = csr_wdata[ROW_W-1:0];
            CSR_VIEW_Z_ROW:       cfg_in.z_row           = csr_wdata[ROW_W-1:0];
            CSR_VIEW_TRANSLATION: cfg_in.translation     = csr_wdata[3*COORD_W-1:0];
            CSR_SIDE_PLANES:      cfg_in.side_planes     = csr_wdata;
            CSR_VERTICAL_PLANES:  cfg_in.vertical_planes = csr_wdata;
            CSR_CLIP_DEPTHS:      cfg_in.clip_depths     = csr_wdata[2*COORD_W-1:0];
            default:              cfg_in = cfg_ff;   // unused index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity: 1.0 (Q1.14) on the diagonal
         cfg_ff.x_row           <= ROW_W'(1) << (FRAC_W + 0*COEF_W);
         cfg_ff.y_row           <= ROW_W'(1) << (FRAC_W + 1*COEF_W);
         cfg_ff.z_row           <= ROW_W'(1) << (FRAC_W + 2*COEF_W);
         cfg_ff.translation     <= '0;
         cfg_ff.side_planes     <= '0;
         cfg_ff.vertical_planes <= '0;
         cfg_ff.clip_depths     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- stage control ------------------------------------------------------
   // A stage moves on when it is empty or the stage after it moves on, so
   // bubbles close up while the result register waits.
   always_comb begin
      adv.s4 = !v4_ff || rsp_tready;
      adv.s3 = !v3_ff || adv.s4;
      adv.s2 = !v2_ff || adv.s3;
      adv.s1 = !v1_ff || adv.s2;
      v1_in  = adv.s1 ? req_tvalid : v1_ff;
      v2_in  = adv.s2 ? v1_ff      : v2_ff;
      v3_in  = adv.s3 ? v2_ff      : v3_ff;
      v4_in  = adv.s4 ? v3_ff      : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_tready = adv.s1;

   // ---- datapath -----------------------------------------------------------
   assign center_x = req_tdata[0*COORD_W +: COORD_W];
   assign center_y = req_tdata[1*COORD_W +: COORD_W];
   assign center_z = req_tdata[2*COORD_W +: COORD_W];
   assign radius   = req_tdata[3*COORD_W +: RAD_W];

   scf_xform u_xform (
      .clock      (clock),
      .adv        (adv),
      .cfg        (cfg_ff),
      .center_x   (center_x),
      .center_y   (center_y),
      .center_z   (center_z),
      .radius     (radius),
      .view_x     (view_x),
      .view_y     (view_y),
      .view_z     (view_z),
      .radius_out (radius_s2)
   );

   // tests run on the unclamped view coordinates; clamping is for output only
   scf_test u_test (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg_ff),
      .view_x  (view_x),
      .view_y  (view_y),
      .view_z  (view_z),
      .radius  (radius_s2),
      .visible (visible),
      .sat_x   (sat_x),
      .sat_y   (sat_y),
      .sat_z   (sat_z)
   );

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {1'b0, sat_z, sat_y, sat_x};
   assign rsp_tuser  = visible;

endmodule

// File: hdl/scf_checker.sv
// ----------------------------------------------------------------------------
// scf_checker : port-level checks for the culling block
// Watches the handshakes and result padding; bound to the top level.
// ----------------------------------------------------------------------------
module scf_checker
   import scf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // an empty result register never back-pressures the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item after reset");

   // padding bit of the result data is zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("result padding bit set");

endmodule

bind sphere_frustum_cull scf_checker u_scf_checker (.*);
